### hdl/assert_macros.svh
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LVSM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled during reset
`define LVSM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: label");

`endif

### hdl/lvsm_pkg.sv
// Package: types and constants of the voice sample mixer.
package lvsm_pkg;

  localparam int FramesPerVoiceDef = 16384;
  localparam int VoiceCountDef     = 5;

  localparam logic [15:0] BgmGainRst    = 16'd22938;
  localparam logic [15:0] EffectGainRst = 16'd42598;

  // Input opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_DEFINE = 3'd2;
  localparam logic [2:0] OP_PLAY   = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;

  // Register indexes
  localparam logic REG_BGM_GAIN    = 1'b0;
  localparam logic REG_EFFECT_GAIN = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_DEFINE,
    CMD_PLAY,
    CMD_STOP
  } cmd_op_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_op_t            op;
    logic        [2:0]  voice;
    logic        [13:0] addr;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic        [14:0] len;
    logic        [14:0] first;
    logic        [14:0] last;
    logic               loop_en;
  } cmd_t;

  typedef struct packed {
    logic [15:0] bgm;
    logic [15:0] effect;
  } gains_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TICK,
    BK_DRAIN,
    BK_DONE
  } bk_state_t;

endpackage

### hdl/lvsm_if.sv
// Interfaces: input command channel and mixed output channel.
interface lvsm_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [2:0]  voice;
  logic        [13:0] sample_address;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic        [14:0] clip_length;
  logic        [14:0] clip_loop_start;
  logic        [14:0] clip_loop_end;
  logic               loop_enable;

  modport source (output valid, opcode, voice, sample_address, left_sample, right_sample,
                  clip_length, clip_loop_start, clip_loop_end, loop_enable, input ready);
  modport sink (input valid, opcode, voice, sample_address, left_sample, right_sample,
                clip_length, clip_loop_start, clip_loop_end, loop_enable, output ready);
endinterface

interface lvsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic        [4:0]  playing_mask;

  modport source (output valid, left_out, right_out, playing_mask, input ready);
  modport sink (input valid, left_out, right_out, playing_mask, output ready);
endinterface

### hdl/lvsm_front.sv
// Front end: accepts input transactions, drops no-op items, resolves clip fields.
module lvsm_front import lvsm_pkg::*; #(
  parameter int FRAMES_PER_VOICE = FramesPerVoiceDef,
  parameter int VOICE_COUNT      = VoiceCountDef
) (
  lvsm_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output cmd_t    q_cmd
);

  localparam int LenCapInt = (FRAMES_PER_VOICE > 32767) ? 32767 : FRAMES_PER_VOICE;
  localparam logic [14:0] LenCap = 15'(LenCapInt);

  logic        keep;
  logic        voice_ok;
  logic [14:0] len_sat;

  assign in_ch.ready = !q_full;

  // Classification
  always_comb begin
    voice_ok = (32'(in_ch.voice) < VOICE_COUNT);
    len_sat  = (in_ch.clip_length > LenCap) ? LenCap : in_ch.clip_length;
    q_cmd    = '0;
    q_cmd.voice   = in_ch.voice;
    q_cmd.addr    = in_ch.sample_address;
    q_cmd.left    = in_ch.left_sample;
    q_cmd.right   = in_ch.right_sample;
    q_cmd.len     = len_sat;
    q_cmd.loop_en = in_ch.loop_enable;
    // keep requested loop points only when they are ordered and inside the clip
    if (in_ch.clip_loop_start < in_ch.clip_loop_end && in_ch.clip_loop_end <= len_sat) begin
      q_cmd.first = in_ch.clip_loop_start;
      q_cmd.last  = in_ch.clip_loop_end;
    end else begin
      q_cmd.first = '0;
      q_cmd.last  = len_sat;
    end
    keep = 1'b0;
    case (in_ch.opcode)
      OP_TICK: begin
        q_cmd.op = CMD_TICK;
        keep     = 1'b1;
      end
      OP_WRITE: begin
        q_cmd.op = CMD_WRITE;
        keep     = voice_ok && (32'(in_ch.sample_address) < FRAMES_PER_VOICE);
      end
      OP_DEFINE: begin
        q_cmd.op = CMD_DEFINE;
        keep     = voice_ok;
      end
      OP_PLAY: begin
        q_cmd.op = CMD_PLAY;
        keep     = voice_ok;
      end
      OP_STOP: begin
        q_cmd.op = CMD_STOP;
        keep     = voice_ok;
      end
      default: begin
        q_cmd.op = CMD_TICK;
        keep     = 1'b0;
      end
    endcase
  end

  assign q_push = in_ch.valid && !q_full && keep;

endmodule

### hdl/lvsm_queue.sv
// Command queue between front and back end.
module lvsm_queue import lvsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int Depth = 4;
  localparam int PW    = $clog2(Depth);

  cmd_t          slot_r [Depth];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

### hdl/lvsm_back.sv
// Back end: sample memory, voice state and the tick mixing pipeline.
module lvsm_back import lvsm_pkg::*; #(
  parameter int FRAMES_PER_VOICE = FramesPerVoiceDef,
  parameter int VOICE_COUNT      = VoiceCountDef
) (
  input  logic clk,
  input  logic rst_n,
  input  gains_t gains,
  input  cmd_t head,
  input  logic q_empty,
  output logic q_pop,
  lvsm_out_if.source out_ch
);

  localparam int Words = VOICE_COUNT * FRAMES_PER_VOICE;
  localparam int AW    = $clog2(Words);
  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AccW  = 36;
  localparam logic [VW-1:0] LastVoice = VW'(VOICE_COUNT - 1);

  logic [31:0] mem [Words];

  bk_state_t state_r, state_nxt;

  logic [14:0] pos_r   [VOICE_COUNT];
  logic [14:0] len_r   [VOICE_COUNT];
  logic [14:0] first_r [VOICE_COUNT];
  logic [14:0] last_r  [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] playing_r, looping_r;

  logic [VW-1:0] k_r;
  logic [VW-1:0] hv;
  logic [AW-1:0] raddr;
  logic          rd_v_r, mul_v_r, out_valid_r;
  logic [31:0]   rdata_r;
  logic [15:0]   gain1_r;
  logic signed [32:0] prod_l_r, prod_r_r;
  logic signed [AccW-1:0] acc_l_r, acc_r_r;
  logic signed [15:0] out_l_r, out_r_r;
  logic [4:0]    mask_r;

  logic [14:0] cur_pos, pos_eff;
  logic        issue;

  assign hv = head.voice[VW-1:0];

  // Current voice evaluation for the tick walk
  always_comb begin
    cur_pos = pos_r[k_r];
    pos_eff = (looping_r[k_r] && cur_pos >= last_r[k_r]) ? first_r[k_r] : cur_pos;
    issue   = (state_r == BK_TICK) && playing_r[k_r] && (pos_eff < len_r[k_r]);
    raddr   = AW'(int'(k_r) * FRAMES_PER_VOICE + int'(pos_eff));
  end

  // Next state and queue pop
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (head.op == CMD_TICK) state_nxt = BK_TICK;
        end
      end
      BK_TICK: begin
        if (k_r == LastVoice) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (!rd_v_r && !mul_v_r) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // Sample memory: write port for commands, registered read for ticks
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && !q_empty && head.op == CMD_WRITE) begin
      mem[AW'(int'(hv) * FRAMES_PER_VOICE + int'(head.addr))] <= {head.right, head.left};
    end
    if (issue) rdata_r <= mem[raddr];
  end

  // Voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        pos_r[i]   <= '0;
        len_r[i]   <= '0;
        first_r[i] <= '0;
        last_r[i]  <= '0;
      end
      playing_r <= '0;
      looping_r <= '0;
      k_r       <= '0;
    end else begin
      case (state_r)
        BK_IDLE: begin
          k_r <= '0;
          if (!q_empty) begin
            case (head.op)
              CMD_DEFINE: begin
                len_r[hv]     <= head.len;
                first_r[hv]   <= head.first;
                last_r[hv]    <= head.last;
                pos_r[hv]     <= '0;
                playing_r[hv] <= 1'b0;
                looping_r[hv] <= 1'b0;
              end
              CMD_PLAY: begin
                pos_r[hv]     <= '0;
                looping_r[hv] <= head.loop_en;
                playing_r[hv] <= 1'b1;
              end
              CMD_STOP: playing_r[hv] <= 1'b0;
              default: ;
            endcase
          end
        end
        BK_TICK: begin
          k_r <= k_r + 1'b1;
          if (playing_r[k_r]) begin
            if (pos_eff >= len_r[k_r]) begin
              playing_r[k_r] <= 1'b0;
              pos_r[k_r]     <= pos_eff;
            end else begin
              pos_r[k_r] <= pos_eff + 15'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Mixing pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) gain1_r <= (k_r == '0) ? gains.bgm : gains.effect;
    if (rd_v_r) begin
      prod_l_r <= $signed(rdata_r[15:0])  * $signed({1'b0, gain1_r});
      prod_r_r <= $signed(rdata_r[31:16]) * $signed({1'b0, gain1_r});
    end
    if (state_r == BK_IDLE) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (mul_v_r) begin
      acc_l_r <= acc_l_r + AccW'(prod_l_r);
      acc_r_r <= acc_r_r + AccW'(prod_r_r);
    end
  end

  // Round to Q1.15 and saturate
  function automatic logic signed [15:0] round_sat(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0] t;
    logic signed [AccW-17:0] q;
    t = s + AccW'(32768);
    q = t[AccW-1:16];
    if (q > (AccW-16)'(32767))       round_sat = 16'sd32767;
    else if (q < -(AccW-16)'(32768)) round_sat = -16'sd32768;
    else                             round_sat = q[15:0];
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == BK_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_DONE && (!out_valid_r || out_ch.ready)) begin
      out_l_r <= round_sat(acc_l_r);
      out_r_r <= round_sat(acc_r_r);
      for (int i = 0; i < 5; i++) begin
        mask_r[i] <= (i < VOICE_COUNT) ? playing_r[i % VOICE_COUNT] : 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_out     = out_l_r;
  assign out_ch.right_out    = out_r_r;
  assign out_ch.playing_mask = mask_r;

endmodule

### hdl/looping_voice_sample_mixer.sv
// A tick result passes the read register, the product registers and the accumulators, then
// is rounded into the output register. Non-tick commands are applied while the back end is
// idle; a tick holds it for one read per voice (single memory read port), then drain and
// output load, which waits on a stalled output. A four-entry queue decouples front and back.
// Reset (synchronous, rst_n low) clears voices, flags and queue; gains go to defaults.
// Sample memory contents are not cleared.
`include "assert_macros.svh"

module looping_voice_sample_mixer import lvsm_pkg::*; #(
  parameter int FRAMES_PER_VOICE = FramesPerVoiceDef,
  parameter int VOICE_COUNT      = VoiceCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  lvsm_in_if.sink     in_ch,
  lvsm_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gains_t gains_r;
  cmd_t   push_cmd, head;
  logic   q_push, q_pop, q_full, q_empty;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.bgm    <= BgmGainRst;
      gains_r.effect <= EffectGainRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BGM_GAIN:    gains_r.bgm    <= pwdata[15:0];
        REG_EFFECT_GAIN: gains_r.effect <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BGM_GAIN:    prdata = {16'd0, gains_r.bgm};
      REG_EFFECT_GAIN: prdata = {16'd0, gains_r.effect};
      default:         prdata = '0;
    endcase
  end

  lvsm_front #(.FRAMES_PER_VOICE(FRAMES_PER_VOICE), .VOICE_COUNT(VOICE_COUNT)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  lvsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lvsm_back #(.FRAMES_PER_VOICE(FRAMES_PER_VOICE), .VOICE_COUNT(VOICE_COUNT)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .gains   (gains_r),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Checks
  `LVSM_ASSERT_IMPLY(a_no_overflow, clk, rst_n, q_push, !q_full)
  `LVSM_ASSERT_IMPLY(a_no_underflow, clk, rst_n, q_pop, !q_empty)
  `LVSM_ASSERT_IMPLY(a_mask_range, clk, rst_n, out_ch.valid, (32'(out_ch.playing_mask) >> VOICE_COUNT) == 0)
  `LVSM_ASSERT_NEXT(a_full_stalls, clk, rst_n, q_full && !q_pop, !q_empty)

endmodule

### sim/looping_voice_sample_mixer_test.sv
// Self-checking testbench for the looping voice sample mixer: random and directed commands.
module looping_voice_sample_mixer_test;
  import lvsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frames = FramesPerVoiceDef;
  localparam int Voices = VoiceCountDef;
  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 64;
  localparam int PhaseItems = 230;

  typedef struct {
    logic        [2:0]  opcode;
    logic        [2:0]  voice;
    logic        [13:0] addr;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic        [14:0] len;
    logic        [14:0] first;
    logic        [14:0] last;
    logic               loop_en;
  } voice_cmd_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic        [4:0]  mask;
  } mix_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  lvsm_in_if in_bus ();
  lvsm_out_if out_bus ();

  looping_voice_sample_mixer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow of the mixer state
  logic [31:0] frame_mem [0:Voices*Frames-1];
  bit          frame_valid [0:Voices*Frames-1];
  logic [14:0] position [Voices];
  logic [14:0] clip_len [Voices];
  logic [14:0] loop_lo [Voices];
  logic [14:0] loop_hi [Voices];
  logic [4:0]  active_voices, looping_voices;
  logic [15:0] bgm_gain, effect_gain;

  voice_cmd_t pending_cmds[$];
  mix_frame_t expected_mixes[$];
  int idle_mode = 0;
  int mismatches = 0;
  int cycles = 0;
  int issued_items = 0;
  bit drain_held = 1'b0;

  function automatic logic signed [15:0] round_sat(longint sum);
    longint q;
    q = (sum + 32768) >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Apply one command to the shadow state; ticks queue an expected mix
  function automatic void predict_cmd(voice_cmd_t c);
    longint suml, sumr, g;
    logic [31:0] w;
    int v;
    mix_frame_t m;
    suml = 0;
    sumr = 0;
    v = c.voice;
    if (c.opcode == OP_TICK) begin
      for (int k = 0; k < Voices; k++) begin
        if (!active_voices[k]) continue;
        if (looping_voices[k] && position[k] >= loop_hi[k]) position[k] = loop_lo[k];
        if (position[k] >= clip_len[k]) begin
          active_voices[k] = 1'b0;
          continue;
        end
        g = (k == 0) ? longint'(bgm_gain) : longint'(effect_gain);
        w = frame_mem[k*Frames + position[k]];
        suml += longint'($signed(w[15:0])) * g;
        sumr += longint'($signed(w[31:16])) * g;
        position[k] = position[k] + 15'd1;
      end
      m.left = round_sat(suml);
      m.right = round_sat(sumr);
      m.mask = active_voices;
      expected_mixes.push_back(m);
    end else if (v < Voices) begin
      case (c.opcode)
        OP_WRITE: begin
          frame_mem[v*Frames + c.addr] = {c.right, c.left};
          frame_valid[v*Frames + c.addr] = 1'b1;
        end
        OP_DEFINE: begin
          clip_len[v] = (c.len > Frames) ? 15'(Frames) : c.len;
          if (c.first < c.last && c.last <= clip_len[v]) begin
            loop_lo[v] = c.first;
            loop_hi[v] = c.last;
          end else begin
            loop_lo[v] = '0;
            loop_hi[v] = clip_len[v];
          end
          position[v] = '0;
          active_voices[v] = 1'b0;
          looping_voices[v] = 1'b0;
        end
        OP_PLAY: begin
          position[v] = '0;
          looping_voices[v] = c.loop_en;
          active_voices[v] = 1'b1;
        end
        OP_STOP: active_voices[v] = 1'b0;
        default: ;
      endcase
    end
  endfunction

  function automatic voice_cmd_t random_fields();
    voice_cmd_t c;
    c.opcode = 3'($urandom);
    c.voice = 3'($urandom);
    c.addr = 14'($urandom);
    c.left = 16'($urandom);
    c.right = 16'($urandom);
    c.len = 15'($urandom);
    c.first = 15'($urandom);
    c.last = 15'($urandom);
    c.loop_en = 1'($urandom);
    return c;
  endfunction

  function automatic void issue(voice_cmd_t c);
    predict_cmd(c);
    pending_cmds.push_back(c);
    issued_items++;
  endfunction

  // Before a tick, fill any frame the tick would read that was never written
  function automatic void issue_tick();
    voice_cmd_t c;
    logic [14:0] p;
    for (int k = 0; k < Voices; k++) begin
      if (!active_voices[k]) continue;
      p = position[k];
      if (looping_voices[k] && p >= loop_hi[k]) p = loop_lo[k];
      if (p < clip_len[k] && !frame_valid[k*Frames + p]) begin
        c = random_fields();
        c.opcode = OP_WRITE;
        c.voice = 3'(k);
        c.addr = p[13:0];
        issue(c);
      end
    end
    c = random_fields();
    c.opcode = OP_TICK;
    issue(c);
  endfunction

  function automatic voice_cmd_t make_cmd(logic [2:0] op, int v, int a, int l, int r,
                                          int len, int lo, int hi, bit lp);
    voice_cmd_t c;
    c = random_fields();
    c.opcode = op;
    c.voice = 3'(v);
    c.addr = 14'(a);
    c.left = 16'(l);
    c.right = 16'(r);
    c.len = 15'(len);
    c.first = 15'(lo);
    c.last = 15'(hi);
    c.loop_en = lp;
    return c;
  endfunction

  // One random command, weighted toward playable clips and ticks
  function automatic void issue_random();
    voice_cmd_t c;
    int r, sel;
    c = random_fields();
    if ($urandom_range(99) < 90) c.voice = 3'($urandom_range(Voices - 1));
    r = $urandom_range(99);
    if (r < 40) begin
      issue_tick();
      return;
    end else if (r < 65) begin
      c.opcode = OP_WRITE;
      if ($urandom_range(3) != 0) c.addr = 14'($urandom_range(63));
    end else if (r < 77) begin
      c.opcode = OP_DEFINE;
      sel = $urandom_range(99);
      if (sel < 70) c.len = 15'($urandom_range(48));
      else if (sel < 85) c.len = 15'($urandom_range(Frames));
      else if (sel < 95) c.len = 15'($urandom_range(32767, Frames));
      else c.len = '0;
      if ($urandom_range(99) < 60 && c.len > 1 && c.len <= Frames) begin
        c.last = 15'($urandom_range(c.len, 1));
        c.first = 15'($urandom_range(c.last - 1));
      end
    end else if (r < 91) begin
      c.opcode = OP_PLAY;
    end else if (r < 97) begin
      c.opcode = OP_STOP;
    end else begin
      c.opcode = 3'($urandom_range(7, 5));
    end
    issue(c);
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_idle();
    case (idle_mode)
      1: return roll(55);
      3: return roll(6);
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      2: return roll(55);
      3: return roll(6);
      default: return 1'b0;
    endcase
  endfunction

  // Input driver: next transaction once the current one is taken
  always @(posedge clk) begin : drive_proc
    voice_cmd_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_cmds.size() > 0 && !sender_idle()) begin
        nxt = pending_cmds.pop_front();
        in_bus.opcode <= nxt.opcode;
        in_bus.voice <= nxt.voice;
        in_bus.sample_address <= nxt.addr;
        in_bus.left_sample <= nxt.left;
        in_bus.right_sample <= nxt.right;
        in_bus.clip_length <= nxt.len;
        in_bus.clip_loop_start <= nxt.first;
        in_bus.clip_loop_end <= nxt.last;
        in_bus.loop_enable <= nxt.loop_en;
        in_bus.valid <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Output monitor: compare each mix transaction with the oldest expectation
  always @(posedge clk) begin : watch_proc
    mix_frame_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_mixes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected mix L=%0d R=%0d mask=%b",
                                         out_bus.left_out, out_bus.right_out,
                                         out_bus.playing_mask);
        end else begin
          want = expected_mixes.pop_front();
          if (out_bus.left_out !== want.left || out_bus.right_out !== want.right ||
              out_bus.playing_mask !== want.mask) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mix mismatch: want L=%0d R=%0d mask=%b, got L=%0d R=%0d mask=%b",
                       want.left, want.right, want.mask, out_bus.left_out,
                       out_bus.right_out, out_bus.playing_mask);
          end
        end
      end
      out_bus.ready <= !receiver_stall();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("looping_voice_sample_mixer_test: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_bus.valid || expected_mixes.size() != 0)
      @(posedge clk);
  endtask

  // APB write: setup then access; lands on the access edge
  task automatic cfg_write(logic idx, logic [15:0] value);
    repeat (SettleCycles) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BGM_GAIN) bgm_gain = value;
    else effect_gain = value;
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.opcode = '0;
    in_bus.voice = '0;
    in_bus.sample_address = '0;
    in_bus.left_sample = '0;
    in_bus.right_sample = '0;
    in_bus.clip_length = '0;
    in_bus.clip_loop_start = '0;
    in_bus.clip_loop_end = '0;
    in_bus.loop_enable = 1'b0;
    out_bus.ready = 1'b1;
    for (int i = 0; i < Voices*Frames; i++) frame_valid[i] = 1'b0;
    for (int k = 0; k < Voices; k++) begin
      position[k] = '0;
      clip_len[k] = '0;
      loop_lo[k] = '0;
      loop_hi[k] = '0;
    end
    active_voices = '0;
    looping_voices = '0;
    bgm_gain = BgmGainRst;
    effect_gain = EffectGainRst;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 5; phase++) begin
      idle_mode = phase % 4;
      case (phase)
        1: begin cfg_write(REG_BGM_GAIN, 16'd0); cfg_write(REG_EFFECT_GAIN, 16'hFFFF); end
        2: begin cfg_write(REG_BGM_GAIN, 16'hFFFF); cfg_write(REG_EFFECT_GAIN, 16'hFFFF); end
        3: begin cfg_write(REG_BGM_GAIN, 16'($urandom)); cfg_write(REG_EFFECT_GAIN, 16'd0); end
        4: begin cfg_write(REG_BGM_GAIN, 16'd1); cfg_write(REG_EFFECT_GAIN, 16'($urandom)); end
        default: ;
      endcase

      if (phase == 0) begin
        // Extremes, looping wrap, bad loop points, overlong and empty clips
        issue(make_cmd(OP_WRITE, 0, 0, 32767, -32768, 0, 0, 0, 0));
        issue(make_cmd(OP_WRITE, 0, 1, -32768, 32767, 0, 0, 0, 0));
        issue(make_cmd(OP_DEFINE, 0, 0, 0, 0, 2, 5, 1, 0));
        issue(make_cmd(OP_PLAY, 0, 0, 0, 0, 0, 0, 0, 1));
        repeat (3) issue_tick();
        issue(make_cmd(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_cmd(OP_WRITE, 4, 16383, -1, 1, 0, 0, 0, 0));
        issue(make_cmd(OP_DEFINE, 4, 0, 0, 0, 32767, 0, 0, 0));
        issue(make_cmd(OP_PLAY, 4, 0, 0, 0, 0, 0, 0, 0));
        issue(make_cmd(OP_PLAY, 1, 0, 0, 0, 0, 0, 0, 1));
        issue_tick();
        issue(make_cmd(OP_WRITE, 7, 3, 100, 100, 0, 0, 0, 0));
        issue(make_cmd(3'd5, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_cmd(3'd6, 1, 0, 0, 0, 0, 0, 0, 0));
        issue(make_cmd(3'd7, 2, 0, 0, 0, 0, 0, 0, 0));
        issue(make_cmd(OP_DEFINE, 2, 0, 0, 0, 3, 1, 3, 0));
        issue(make_cmd(OP_PLAY, 2, 0, 0, 0, 0, 0, 0, 1));
        repeat (5) issue_tick();
        issue(make_cmd(OP_STOP, 6, 0, 0, 0, 0, 0, 0, 0));
      end else if (phase == 2) begin
        // Every voice at full scale with full gain: both channels saturate
        for (int k = 0; k < Voices; k++) begin
          issue(make_cmd(OP_WRITE, k, 0, 32767, -32768, 0, 0, 0, 0));
          issue(make_cmd(OP_DEFINE, k, 0, 0, 0, 1, 0, 0, 0));
          issue(make_cmd(OP_PLAY, k, 0, 0, 0, 0, 0, 0, 0));
        end
        issue_tick();
      end

      // Fill writes count toward the phase budget
      while (issued_items < (phase + 1) * PhaseItems) begin
        issue_random();
        // Hold the sender until the mixer has caught up
        if (phase == 1 && !drain_held && issued_items >= PhaseItems + PhaseItems / 2) begin
          wait_drained();
          drain_held = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("looping_voice_sample_mixer_test: clean");
    end else begin
      $display("looping_voice_sample_mixer_test: errors");
    end
    $finish;
  end

endmodule

### looping_voice_sample_mixer.f
+incdir+hdl
hdl/lvsm_pkg.sv
hdl/lvsm_if.sv
hdl/lvsm_front.sv
hdl/lvsm_queue.sv
hdl/lvsm_back.sv
hdl/looping_voice_sample_mixer.sv
sim/looping_voice_sample_mixer_test.sv
